### rtl/pointer_axis_sync_reporter_macros.svh
// assertion macros for the pointer axis sync reporter
`ifndef POINTER_AXIS_SYNC_REPORTER_MACROS_SVH
`define POINTER_AXIS_SYNC_REPORTER_MACROS_SVH
`ifndef SYNTHESIS
`define PASR_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pasr assertion failed");
`define PASR_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pasr assertion failed");
`else
`define PASR_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define PASR_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

### rtl/pasr_pkg.sv
// types, constants and the sine table of the pointer axis sync reporter
`timescale 1ns / 1ps
package pasr_pkg;

	localparam int MAX_AXES       = 16;
	localparam int AXIS_COUNT_DEF = 16;
	localparam int ADDR_W         = 5;
	localparam int QUOT_W         = 16;
	localparam int NUM_W          = 48;
	localparam int DEN_W          = 32;
	localparam int MUL_A_W        = 33;
	localparam int MUL_B_W        = 17;
	localparam int PROD_W         = MUL_A_W + MUL_B_W;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_SYNC   = 1'b1;

	localparam logic [2:0] REG_PRESENT  = 3'd0;
	localparam logic [2:0] REG_RAW_XMIN = 3'd1;
	localparam logic [2:0] REG_RAW_XMAX = 3'd2;
	localparam logic [2:0] REG_RAW_YMIN = 3'd3;
	localparam logic [2:0] REG_RAW_YMAX = 3'd4;
	localparam logic [2:0] REG_AREA_SZ  = 3'd5;
	localparam logic [2:0] REG_AREA_OFS = 3'd6;
	localparam logic [2:0] REG_ORIENT   = 3'd7;

	localparam logic [9:0] DEG_90  = 10'd90;
	localparam logic [9:0] DEG_45  = 10'd45;
	localparam logic [9:0] DEG_135 = 10'd135;
	localparam logic [9:0] DEG_180 = 10'd180;
	localparam logic [9:0] DEG_225 = 10'd225;
	localparam logic [9:0] DEG_270 = 10'd270;
	localparam logic [9:0] DEG_315 = 10'd315;
	localparam logic [9:0] DEG_360 = 10'd360;

	typedef struct packed {
		logic              command;
		logic [3:0]        axis_index;
		logic signed [31:0] axis_value;
		logic              axis_mode;
	} item_t;

	typedef struct packed {
		logic              run_absolute;
		logic [3:0]        run_first_axis;
		logic [4:0]        run_length;
		logic [3:0]        out_axis;
		logic signed [31:0] out_value;
		logic              last_in_run;
		logic              last_of_sync;
	} result_t;

	typedef struct packed {
		logic [15:0]        present_mask;
		logic signed [31:0] raw_x_min;
		logic signed [31:0] raw_x_max;
		logic signed [31:0] raw_y_min;
		logic signed [31:0] raw_y_max;
		logic [31:0]        area_size;
		logic [31:0]        area_offset;
		logic [10:0]        orientation;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef logic [90:0][14:0] sin_tab_t;

	// long division towards zero, only run while the table is built
	function automatic longint div_trunc(input longint n, input longint d);
		logic [63:0] un;
		logic [63:0] ud;
		logic [63:0] q;
		logic [63:0] r;
		logic        neg;
		neg = (n < 0) != (d < 0);
		un  = (n < 0) ? 64'(-n) : 64'(n);
		ud  = (d < 0) ? 64'(-d) : 64'(d);
		q   = '0;
		r   = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], un[b]};
			if (r >= ud) begin
				r    = r - ud;
				q[b] = 1'b1;
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// quarter wave of round(16384*sin(k deg)) from a Q30 series
	function automatic sin_tab_t build_sin_table();
		sin_tab_t t;
		longint   x;
		longint   x2;
		longint   term;
		longint   sum;
		t = '0;
		for (int k = 0; k <= 90; k++) begin
			x = div_trunc(longint'(k) * 64'sd3373259426 + 64'sd90, 64'sd180);
			x2 = (x * x) >>> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = div_trunc(-(term * x2), 64'sd1073741824 * longint'(2 * n)
					* longint'(2 * n + 1));
				sum = sum + term;
			end
			if (sum < 0) sum = 0;
			t[k] = 15'((sum + 64'sd32768) >>> 16);
		end
		return t;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_table();

	// angle below 360
	function automatic logic signed [15:0] sin_q14(input logic [9:0] d);
		logic signed [15:0] r;
		if (d <= DEG_90)
			r = $signed({1'b0, SIN_TAB[7'(d)]});
		else if (d <= DEG_180)
			r = $signed({1'b0, SIN_TAB[7'(DEG_180 - d)]});
		else if (d <= DEG_270)
			r = -$signed({1'b0, SIN_TAB[7'(d - DEG_180)]});
		else
			r = -$signed({1'b0, SIN_TAB[7'(DEG_360 - d)]});
		return r;
	endfunction

endpackage

### rtl/pointer_axis_sync_reporter.sv
// top level: axis store, sync sequencer and result register
`timescale 1ns / 1ps
// An axis update is taken while the block is idle and the block is ready again at once.
// A sync holds item_stall high while it works: PREP fills and flips X/Y, ROT rotates
// them on the shared multiplier when the angle is not zero, then for absolute X/Y a
// scaling pass per axis runs SC0 to SC3, starts the divider in SC4 and waits in DIVW on
// its sixteen quotient steps, or goes straight to SCFIN when the value clamps and no
// division is needed. The report walk follows: FIND skips axes not updated or starts a
// run, RLEN finds the run's length, EMIT sends one result beat per axis of the run while
// the receiver takes them, and FIND finishes once past the last present axis. The result
// register lets a new item be taken while the last beat still waits.
module pointer_axis_sync_reporter #(
	parameter int AXIS_COUNT = pasr_pkg::AXIS_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  pasr_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output pasr_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pasr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

`include "pointer_axis_sync_reporter_macros.svh"

	localparam int D  = (AXIS_COUNT < pasr_pkg::MAX_AXES) ? AXIS_COUNT : pasr_pkg::MAX_AXES;
	localparam int AW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_ROT   = 4'd2;
	localparam logic [3:0] S_SC0   = 4'd3;
	localparam logic [3:0] S_SC1   = 4'd4;
	localparam logic [3:0] S_SC2   = 4'd5;
	localparam logic [3:0] S_SC3   = 4'd6;
	localparam logic [3:0] S_SC4   = 4'd7;
	localparam logic [3:0] S_DIVW  = 4'd8;
	localparam logic [3:0] S_SCFIN = 4'd9;
	localparam logic [3:0] S_FIND  = 4'd10;
	localparam logic [3:0] S_RLEN  = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	pasr_pkg::cfg_t     cfg;
	pasr_pkg::div_req_t div_req;
	logic [pasr_pkg::QUOT_W-1:0] div_q;
	logic                        div_done;

	logic signed [pasr_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pasr_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pasr_pkg::PROD_W-1:0]  prod;

	logic [3:0]         state_q;
	logic [2:0]         step_q;
	logic               axis_sel_q;
	logic signed [31:0] store_q [D];
	logic [D-1:0]       upd_q;
	logic [D-1:0]       abs_q;
	logic signed [31:0] last_x_q;
	logic signed [31:0] last_y_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] nx_q;
	logic               abs_xy_q;
	logic signed [32:0] c_q;
	logic signed [32:0] span_q;
	logic signed [33:0] d_q;
	logic [33:0]        ad_q;
	logic [31:0]        as_q;
	logic               neg_q;
	logic               zero_q;
	logic [15:0]        rq_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      start_q;
	logic [CW-1:0]      end_q;
	logic [CW-1:0]      a_q;
	logic               mode_q;
	logic               res_valid_q;
	pasr_pkg::result_t  res_q;

	logic               accept;
	logic               upd_ok;
	logic [4:0]         cnt_raw;
	logic [CW-1:0]      count;
	logic               later;
	logic               ld;
	logic [9:0]         rot;
	logic [9:0]         cang;
	logic signed [15:0] sin_v;
	logic signed [15:0] cos_v;
	logic               swap;
	logic               xy_go;
	logic signed [31:0] fx;
	logic signed [31:0] fy;
	logic signed [31:0] sv;
	logic signed [31:0] lo;
	logic signed [31:0] hi;
	logic [15:0]        sz;
	logic [15:0]        ofs;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -33'sh0_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// divide by 16384 towards zero, then saturate
	function automatic logic signed [31:0] q14_trunc(input logic signed [47:0] v);
		logic signed [47:0] t;
		logic signed [33:0] s;
		t = v + (v[47] ? 48'sd16383 : 48'sd0);
		s = 34'(t >>> 14);
		return sat32(33'(s));
	endfunction

	pasr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pasr_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pasr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quot   (div_q),
		.done   (div_done)
	);

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign upd_ok       = ({1'b0, item.axis_index} < 5'(D))
		&& cfg.present_mask[item.axis_index];
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign ld           = (state_q == S_EMIT) && (!res_valid_q || !result_stall);

	// rotation angle and table lookups
	always_comb begin
		rot = {1'b0, cfg.orientation[10:2]};
		if (rot >= pasr_pkg::DEG_360) rot = rot - pasr_pkg::DEG_360;
		cang = rot + pasr_pkg::DEG_90;
		if (cang >= pasr_pkg::DEG_360) cang = cang - pasr_pkg::DEG_360;
		sin_v = pasr_pkg::sin_q14(rot);
		cos_v = pasr_pkg::sin_q14(cang);
		swap  = (rot >= pasr_pkg::DEG_45 && rot < pasr_pkg::DEG_135)
			|| (rot >= pasr_pkg::DEG_225 && rot < pasr_pkg::DEG_315);
	end

	always_comb begin
		cnt_raw = '0;
		for (int i = 0; i < pasr_pkg::MAX_AXES; i++)
			if (cfg.present_mask[i]) cnt_raw = 5'(i + 1);
		count = (cnt_raw > 5'(D)) ? CW'(D) : CW'(cnt_raw);
	end

	// any updated axis beyond the current run
	always_comb begin
		later = 1'b0;
		for (int p = 0; p < D; p++)
			if (CW'(p) >= end_q && CW'(p) < count && upd_q[p]) later = 1'b1;
	end

	// fill and per-axis scaling operands
	always_comb begin
		xy_go = (cfg.present_mask[1:0] == 2'b11) && (upd_q[0] || upd_q[1])
			&& (abs_q[0] == abs_q[1]);
		fx = upd_q[0] ? store_q[0] : last_x_q;
		fy = upd_q[1] ? store_q[1] : last_y_q;
		if (!axis_sel_q) begin
			sv  = store_q[0];
			lo  = swap ? cfg.raw_y_min : cfg.raw_x_min;
			hi  = swap ? cfg.raw_y_max : cfg.raw_x_max;
			sz  = cfg.area_size[15:0];
			ofs = cfg.area_offset[15:0];
		end else begin
			sv  = store_q[1];
			lo  = swap ? cfg.raw_x_min : cfg.raw_y_min;
			hi  = swap ? cfg.raw_x_max : cfg.raw_y_max;
			sz  = cfg.area_size[31:16];
			ofs = cfg.area_offset[31:16];
		end
	end

	always_comb begin
		mul_a = 33'(store_q[0]);
		mul_b = 17'(cos_v);
		if (state_q == S_ROT) begin
			case (step_q)
				3'd1: begin
					mul_a = 33'(store_q[1]);
					mul_b = 17'(sin_v);
				end
				3'd2: begin
					mul_a = 33'(store_q[1]);
					mul_b = 17'(cos_v);
				end
				3'd3: begin
					mul_a = 33'(store_q[0]);
					mul_b = 17'(sin_v);
				end
				default: ;
			endcase
		end else if (state_q == S_SC3) begin
			mul_a = $signed({1'b0, ad_q[31:0]});
			mul_b = $signed({1'b0, sz});
		end
	end

	always_comb begin
		div_req.start = (state_q == S_SC4);
		div_req.num   = prod[pasr_pkg::NUM_W-1:0];
		div_req.den   = as_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			axis_sel_q  <= 1'b0;
			upd_q       <= '0;
			abs_q       <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			abs_xy_q    <= 1'b0;
			ptr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ld)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.command == pasr_pkg::CMD_SYNC) begin
							state_q <= S_PREP;
						end else if (upd_ok) begin
							upd_q[item.axis_index[AW-1:0]] <= 1'b1;
							abs_q[item.axis_index[AW-1:0]] <= item.axis_mode;
						end
					end
				end
				S_PREP: begin
					ptr_q      <= '0;
					step_q     <= '0;
					axis_sel_q <= 1'b0;
					abs_xy_q   <= abs_q[0];
					if (xy_go) begin
						last_x_q <= fx;
						last_y_q <= fy;
						if (rot != '0)
							state_q <= S_ROT;
						else if (abs_q[0])
							state_q <= S_SC0;
						else
							state_q <= S_FIND;
					end else begin
						state_q <= S_FIND;
					end
				end
				S_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						upd_q[0] <= 1'b1;
						upd_q[1] <= 1'b1;
						state_q  <= abs_xy_q ? S_SC0 : S_FIND;
					end
				end
				S_SC0:  state_q <= S_SC1;
				S_SC1:  state_q <= S_SC2;
				S_SC2:  state_q <= S_SC3;
				S_SC3: begin
					if (zero_q || neg_q || ad_q >= {2'b00, as_q})
						state_q <= S_SCFIN;
					else
						state_q <= S_SC4;
				end
				S_SC4:  state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) state_q <= S_SCFIN;
				end
				S_SCFIN: begin
					axis_sel_q <= 1'b1;
					state_q    <= axis_sel_q ? S_FIND : S_SC0;
				end
				S_FIND: begin
					if (ptr_q >= count)
						state_q <= S_IDLE;
					else if (!upd_q[ptr_q[AW-1:0]])
						ptr_q <= ptr_q + 1'b1;
					else
						state_q <= S_RLEN;
				end
				S_RLEN: begin
					if (!(end_q < count && upd_q[end_q[AW-1:0]]
						&& abs_q[end_q[AW-1:0]] == mode_q))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (ld) begin
						upd_q[a_q[AW-1:0]] <= 1'b0;
						if (a_q == end_q - 1'b1) begin
							ptr_q   <= end_q;
							state_q <= S_FIND;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && item.command == pasr_pkg::CMD_UPDATE && upd_ok)
					store_q[item.axis_index[AW-1:0]] <= item.axis_value;
			end
			S_PREP: begin
				if (xy_go) begin
					if (abs_q[0]) begin
						store_q[0] <= cfg.orientation[0]
							? sat32(33'(cfg.raw_x_max) - 33'(fx)) : fx;
						store_q[1] <= cfg.orientation[1]
							? sat32(33'(cfg.raw_y_max) - 33'(fy)) : fy;
					end else begin
						store_q[0] <= cfg.orientation[0] ? sat32(-33'(fx)) : fx;
						store_q[1] <= cfg.orientation[1] ? sat32(-33'(fy)) : fy;
					end
				end
			end
			S_ROT: begin
				case (step_q)
					3'd1: acc_q <= 48'(prod);
					3'd2: acc_q <= acc_q - 48'(prod);
					3'd3: begin
						nx_q  <= q14_trunc(acc_q);
						acc_q <= 48'(prod);
					end
					3'd4: acc_q <= acc_q + 48'(prod);
					3'd5: begin
						store_q[0] <= nx_q;
						store_q[1] <= q14_trunc(acc_q);
					end
					default: ;
				endcase
			end
			S_SC0: begin
				c_q    <= sv[31] ? 33'(hi) + 33'(sv) : 33'(sv);
				span_q <= 33'(hi) - 33'(lo);
			end
			S_SC1: d_q <= 34'(c_q) - 34'(lo);
			S_SC2: begin
				ad_q   <= d_q[33] ? 34'(-d_q) : 34'(d_q);
				as_q   <= span_q[32] ? 32'(-span_q) : 32'(span_q);
				neg_q  <= d_q[33] != span_q[32];
				zero_q <= (d_q == '0) || (span_q == '0) || (sz == '0);
			end
			S_SC3: begin
				if (zero_q || neg_q)
					rq_q <= '0;
				else
					rq_q <= sz;
			end
			S_DIVW: begin
				if (div_done) rq_q <= div_q;
			end
			S_SCFIN: begin
				store_q[AW'(axis_sel_q)] <= $signed({16'd0, rq_q}) + 32'(signed'(ofs));
			end
			S_FIND: begin
				start_q <= ptr_q;
				end_q   <= ptr_q + 1'b1;
				a_q     <= ptr_q;
				mode_q  <= abs_q[ptr_q[AW-1:0]];
			end
			S_RLEN: begin
				if (end_q < count && upd_q[end_q[AW-1:0]]
					&& abs_q[end_q[AW-1:0]] == mode_q)
					end_q <= end_q + 1'b1;
			end
			S_EMIT: begin
				if (ld) begin
					res_q.run_absolute   <= mode_q;
					res_q.run_first_axis <= 4'(start_q);
					res_q.run_length     <= 5'(end_q - start_q);
					res_q.out_axis       <= 4'(a_q);
					res_q.out_value      <= store_q[a_q[AW-1:0]];
					res_q.last_in_run    <= (a_q == end_q - 1'b1);
					res_q.last_of_sync   <= (a_q == end_q - 1'b1) && !later;
					a_q                  <= a_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	`PASR_ASSERT_NXT(a_sync_enters_prep, clk, arst_n, accept && item.command == pasr_pkg::CMD_SYNC, state_q == S_PREP)
	`PASR_ASSERT_IMP(a_emit_in_run, clk, arst_n, state_q == S_EMIT, a_q < end_q && start_q <= a_q)
	`PASR_ASSERT_IMP(a_sync_end_is_run_end, clk, arst_n, res_valid_q && res_q.last_of_sync, res_q.last_in_run)

endmodule

### rtl/pasr_cfg.sv
// configuration register bank behind the apb-style port
`timescale 1ns / 1ps
module pasr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pasr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output pasr_pkg::cfg_t              cfg
);

	pasr_pkg::cfg_t cfg_q;
	logic [2:0]     idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.present_mask <= 16'd3;
			cfg_q.raw_x_min    <= '0;
			cfg_q.raw_x_max    <= 32'sd4095;
			cfg_q.raw_y_min    <= '0;
			cfg_q.raw_y_max    <= 32'sd4095;
			cfg_q.area_size    <= '0;
			cfg_q.area_offset  <= '0;
			cfg_q.orientation  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				pasr_pkg::REG_PRESENT:  cfg_q.present_mask <= pwdata[15:0];
				pasr_pkg::REG_RAW_XMIN: cfg_q.raw_x_min    <= $signed(pwdata);
				pasr_pkg::REG_RAW_XMAX: cfg_q.raw_x_max    <= $signed(pwdata);
				pasr_pkg::REG_RAW_YMIN: cfg_q.raw_y_min    <= $signed(pwdata);
				pasr_pkg::REG_RAW_YMAX: cfg_q.raw_y_max    <= $signed(pwdata);
				pasr_pkg::REG_AREA_SZ:  cfg_q.area_size    <= pwdata;
				pasr_pkg::REG_AREA_OFS: cfg_q.area_offset  <= pwdata;
				pasr_pkg::REG_ORIENT:   cfg_q.orientation  <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pasr_pkg::REG_PRESENT:  prdata = {16'd0, cfg_q.present_mask};
			pasr_pkg::REG_RAW_XMIN: prdata = cfg_q.raw_x_min;
			pasr_pkg::REG_RAW_XMAX: prdata = cfg_q.raw_x_max;
			pasr_pkg::REG_RAW_YMIN: prdata = cfg_q.raw_y_min;
			pasr_pkg::REG_RAW_YMAX: prdata = cfg_q.raw_y_max;
			pasr_pkg::REG_AREA_SZ:  prdata = cfg_q.area_size;
			pasr_pkg::REG_AREA_OFS: prdata = cfg_q.area_offset;
			pasr_pkg::REG_ORIENT:   prdata = {21'd0, cfg_q.orientation};
			default:                prdata = '0;
		endcase
	end

endmodule

### rtl/pasr_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module pasr_mul (
	input  logic                               clk,
	input  logic signed [pasr_pkg::MUL_A_W-1:0] a,
	input  logic signed [pasr_pkg::MUL_B_W-1:0] b,
	output logic signed [pasr_pkg::PROD_W-1:0]  prod
);

	logic signed [pasr_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= pasr_pkg::PROD_W'(a) * pasr_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

### rtl/pasr_div.sv
// restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module pasr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pasr_pkg::div_req_t          req,
	output logic [pasr_pkg::QUOT_W-1:0] quot,
	output logic                        done
);

	localparam int NW = pasr_pkg::NUM_W;
	localparam int KW = $clog2(pasr_pkg::QUOT_W);

	logic                        busy_q;
	logic                        done_q;
	logic [KW-1:0]               k_q;
	logic [NW-1:0]               rem_q;
	logic [pasr_pkg::DEN_W-1:0]  den_q;
	logic [pasr_pkg::QUOT_W-1:0] q_q;
	logic [NW:0]                 trial;

	assign trial = {1'b0, rem_q} - ({(NW + 1 - pasr_pkg::DEN_W)'(0), den_q} << k_q);
	assign quot  = q_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && k_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			k_q   <= KW'(pasr_pkg::QUOT_W - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (!trial[NW]) begin
				rem_q    <= trial[NW-1:0];
				q_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 1'b1;
		end
	end

endmodule

### tb/tb_top.sv
// self-checking testbench of the pointer axis sync reporter
`timescale 1ns / 1ps
module tb_top;

	class sync_scoreboard;
		logic [15:0] mask;
		longint      xmin, xmax, ymin, ymax;
		logic [31:0] asize, aofs;
		logic [10:0] orient;
		longint      store [16];
		bit          upd [16];
		bit          absm [16];
		longint      lastx, lasty;
		longint      qsin [91];
		pasr_pkg::result_t pending [$];
		int          errors;

		function new();
			longint x, x2, term, sum;
			for (int k = 0; k <= 90; k++) begin
				x = (longint'(k) * 64'sd3373259426 + 64'sd90) / 64'sd180;
				x2 = (x * x) >>> 30;
				term = x;
				sum = x;
				for (int n = 1; n <= 7; n++) begin
					term = -(term * x2) / (64'sd1073741824 * (2 * n) * (2 * n + 1));
					sum += term;
				end
				if (sum < 0) sum = 0;
				qsin[k] = (sum + 32768) >>> 16;
			end
			mask = 16'h3; xmin = 0; xmax = 4095; ymin = 0; ymax = 4095;
			asize = '0; aofs = '0; orient = '0;
			for (int i = 0; i < 16; i++) begin
				store[i] = 0; upd[i] = 0; absm[i] = 0;
			end
			lastx = 0; lasty = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				pasr_pkg::REG_PRESENT:  mask = v[15:0];
				pasr_pkg::REG_RAW_XMIN: xmin = longint'($signed(v));
				pasr_pkg::REG_RAW_XMAX: xmax = longint'($signed(v));
				pasr_pkg::REG_RAW_YMIN: ymin = longint'($signed(v));
				pasr_pkg::REG_RAW_YMAX: ymax = longint'($signed(v));
				pasr_pkg::REG_AREA_SZ:  asize = v;
				pasr_pkg::REG_AREA_OFS: aofs = v;
				pasr_pkg::REG_ORIENT:   orient = v[10:0];
				default: ;
			endcase
		endfunction

		function longint sine(int d);
			d = d % 360;
			if (d <= 90) return qsin[d];
			if (d <= 180) return qsin[180 - d];
			if (d <= 270) return -qsin[d - 180];
			return -qsin[360 - d];
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint scale(longint c, longint size, longint lo, longint hi);
			longint span, r;
			span = hi - lo;
			if (c < 0) c = hi + c;
			r = (span == 0) ? 0 : (size * (c - lo)) / span;
			if (r < 0) r = 0;
			if (r > size) r = size;
			return r;
		endfunction

		function void rotate(int rot);
			longint c, s, x, y;
			c = sine(rot + 90);
			s = sine(rot);
			x = store[0];
			y = store[1];
			store[0] = sat((x * c - y * s) / 16384);
			store[1] = sat((y * c + x * s) / 16384);
			upd[0] = 1;
			upd[1] = 1;
		endfunction

		function void fill();
			if (upd[0]) lastx = store[0]; else store[0] = lastx;
			if (upd[1]) lasty = store[1]; else store[1] = lasty;
		endfunction

		function void note_item(pasr_pkg::item_t it);
			int      count, rot, i, start, n;
			longint  lx, hx, ly, hy;
			bit      mode;
			pasr_pkg::result_t r;
			if (it.command != pasr_pkg::CMD_SYNC) begin
				if (mask[it.axis_index]) begin
					store[it.axis_index] = longint'(it.axis_value);
					absm[it.axis_index] = it.axis_mode;
					upd[it.axis_index] = 1;
				end
				return;
			end
			count = 0;
			for (int k = 0; k < 16; k++) if (mask[k]) count = k + 1;
			rot = int'(orient[10:2]) % 360;
			if (mask[1:0] == 2'b11 && (upd[0] || upd[1])) begin
				if (absm[0] && absm[1]) begin
					lx = xmin; hx = xmax; ly = ymin; hy = ymax;
					fill();
					if (orient[0]) store[0] = sat(xmax - store[0]);
					if (orient[1]) store[1] = sat(ymax - store[1]);
					// ranges trade places near a quarter turn
					if ((rot >= 45 && rot < 135) || (rot >= 225 && rot < 315)) begin
						lx = ymin; hx = ymax; ly = xmin; hy = xmax;
					end
					if (rot != 0) rotate(rot);
					store[0] = scale(store[0], longint'(asize[15:0]), lx, hx)
						+ longint'($signed(aofs[15:0]));
					store[1] = scale(store[1], longint'(asize[31:16]), ly, hy)
						+ longint'($signed(aofs[31:16]));
				end else if (!absm[0] && !absm[1]) begin
					fill();
					if (orient[0]) store[0] = sat(-store[0]);
					if (orient[1]) store[1] = sat(-store[1]);
					if (rot != 0) rotate(rot);
				end
			end
			n = 0;
			i = 0;
			while (i < count) begin
				if (!upd[i]) begin
					i++;
				end else begin
					mode = absm[i];
					start = i;
					while (i < count && upd[i] && absm[i] == mode) begin
						upd[i] = 0;
						i++;
					end
					for (int a = start; a < i; a++) begin
						r.run_absolute = mode;
						r.run_first_axis = 4'(start);
						r.run_length = 5'(i - start);
						r.out_axis = 4'(a);
						r.out_value = 32'(store[a]);
						r.last_in_run = (a == i - 1);
						r.last_of_sync = 0;
						pending.push_back(r);
						n++;
					end
				end
			end
			if (n > 0)
				pending[$].last_of_sync = 1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare(string field, longint got, longint want);
			if (got != want) report($sformatf("%s got %0d want %0d", field, got, want));
		endtask

		task check_result(pasr_pkg::result_t got);
			pasr_pkg::result_t want;
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = pending.pop_front();
			compare("run_absolute", got.run_absolute, want.run_absolute);
			compare("run_first_axis", got.run_first_axis, want.run_first_axis);
			compare("run_length", got.run_length, want.run_length);
			compare("out_axis", got.out_axis, want.out_axis);
			compare("out_value", longint'(got.out_value), longint'(want.out_value));
			compare("last_in_run", got.last_in_run, want.last_in_run);
			compare("last_of_sync", got.last_of_sync, want.last_of_sync);
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        item_valid;
	logic                        item_stall;
	pasr_pkg::item_t             item;
	logic                        result_valid;
	logic                        result_stall;
	pasr_pkg::result_t           result;
	logic                        psel, penable, pwrite;
	logic [pasr_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	sync_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	int  quiet_cycles;

	pointer_axis_sync_reporter uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side: random stall, and one long hold-off on request
	initial begin
		result_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				result_stall = 1;
				repeat (400) @(negedge clk);
			end
			result_stall = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
			|| psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(pasr_pkg::item_t it);
		while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
			item_valid = 0;
			@(negedge clk);
		end
		item_valid = 1;
		item = it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_update(int idx, logic [31:0] v, logic mode);
		pasr_pkg::item_t it;
		it.command = pasr_pkg::CMD_UPDATE;
		it.axis_index = 4'(idx);
		it.axis_value = v;
		it.axis_mode = mode;
		send_item(it);
	endtask

	task automatic send_sync();
		pasr_pkg::item_t it;
		it = pasr_pkg::item_t'(38'({$urandom, $urandom}));
		it.command = pasr_pkg::CMD_SYNC;
		send_item(it);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		psel = 1; penable = 0; pwrite = 1;
		paddr = pasr_pkg::ADDR_W'({idx, 2'b00});
		pwdata = v;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// only once the block has emptied out
	task automatic settle();
		item_valid = 0;
		while (sb.pending.size() > 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_all(logic [15:0] m, logic [31:0] x0, logic [31:0] x1,
		logic [31:0] y0, logic [31:0] y1, logic [31:0] sz, logic [31:0] ofs,
		logic [10:0] ori);
		settle();
		reg_write(pasr_pkg::REG_PRESENT, {16'h0, m});
		reg_write(pasr_pkg::REG_RAW_XMIN, x0);
		reg_write(pasr_pkg::REG_RAW_XMAX, x1);
		reg_write(pasr_pkg::REG_RAW_YMIN, y0);
		reg_write(pasr_pkg::REG_RAW_YMAX, y1);
		reg_write(pasr_pkg::REG_AREA_SZ, sz);
		reg_write(pasr_pkg::REG_AREA_OFS, ofs);
		reg_write(pasr_pkg::REG_ORIENT, {21'h0, ori});
	endtask

	function automatic logic [31:0] rand_value();
		if ($urandom_range(1)) return 32'($signed($urandom_range(12288)) - 4096);
		return $urandom;
	endfunction

	task automatic run_random(int n);
		int  sent;
		int  k;
		bit  m;
		pasr_pkg::item_t it;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 75) begin
				m = 1'($urandom_range(1));
				k = $urandom_range(1, 3);
				repeat (k) begin
					case ($urandom_range(3))
						0: send_update(0, rand_value(), m);
						1: send_update(1, rand_value(), m);
						2: send_update(1, rand_value(), 1'($urandom_range(1)));
						default: send_update($urandom_range(15), rand_value(),
							1'($urandom_range(1)));
					endcase
				end
				send_sync();
				sent += k + 1;
			end else begin
				it = pasr_pkg::item_t'(38'({$urandom, $urandom}));
				send_item(it);
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		item_valid = 0;
		item = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// defaults after reset: area of zero size, but X alone in absolute mode is not scaled
		send_update(0, 32'd100, 1);
		send_sync();
		send_sync();
		send_update(2, 32'd5, 0);
		send_sync();

		set_all(16'hFFFF, 32'd0, 32'd4095, 32'd0, 32'd4095, {16'd480, 16'd800}, '0, '0);
		send_update(0, 32'h7FFFFFFF, 1);
		send_update(1, 32'h80000000, 1);
		send_sync();
		send_update(1, 32'd2000, 1);
		send_sync();
		send_update(0, 32'hFFFFFFFF, 0);
		send_update(1, 32'd7, 0);
		send_update(15, 32'h80000000, 0);
		send_update(14, 32'h7FFFFFFF, 1);
		send_sync();
		send_update(0, 32'd10, 1);
		send_update(1, 32'd10, 0);
		send_update(3, 32'd3, 1);
		send_sync();
		send_update(0, 32'd1, 0);
		send_update(2, 32'd2, 1);
		send_update(3, 32'd3, 0);
		send_update(4, 32'd4, 0);
		send_sync();
		run_random(17);

		set_all(16'hFFFF, -32'sd1000, 32'd1000, -32'sd500, 32'd500, 32'hFFFFFFFF,
			{16'd7, -16'sd5}, {9'd90, 2'b01});
		send_idle_pct = 68;
		send_update(0, 32'h80000000, 0);
		send_update(1, 32'h80000000, 0);
		send_sync();
		run_random(17);

		// raw range at the extremes, flips on both axes, awkward angle
		set_all(16'($urandom | 32'h3), 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, '0, 32'hFFFFFFFF, 11'h7FF);
		send_idle_pct = 0;
		recv_stall_pct = 68;
		hold_req = 1;
		run_random(17);

		// zero span on X
		set_all(16'($urandom), 32'd100, 32'd100, rand_value(), rand_value(), $urandom,
			$urandom, {9'd45, 2'b10});
		send_idle_pct = 18;
		recv_stall_pct = 18;
		run_random(17);

		set_all(16'h0003, rand_value(), rand_value(), rand_value(), rand_value(),
			$urandom, $urandom, {9'd315, 2'($urandom)});
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(17);

		settle();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
